// ----- src/imu_gradient_attitude_update_defines.svh -----
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef IMU_GRADIENT_ATTITUDE_UPDATE_DEFINES_SVH
`define IMU_GRADIENT_ATTITUDE_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define IGAU_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IGAU_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/igau_pkg.sv -----
`timescale 1ns / 1ps
package igau_pkg;

	// Datapath widths.
	localparam int A_W     = 17;
	localparam int B_W     = 40;
	localparam int P_W     = A_W + B_W;
	localparam int ACC_W   = 64;
	localparam int R_W     = 34;
	localparam int F_W     = 35;
	localparam int D_W     = 38;
	localparam int MAG_W   = 53;
	localparam int NRM_W   = 30;
	localparam int NORM_W  = 32;
	localparam int QU_W    = 15;
	localparam int SQ_SH   = 15;

	// Iteration counts of the root and divide unit.
	localparam int ROOT_ITER = 32;
	localparam int DIV_ITER  = 15;
	localparam int ROOT_TOP  = 62;

	// Fixed constants.
	localparam logic signed [15:0] Q_ONE      = 16'sd16384;
	localparam logic [15:0]        PERIOD_RST = 16'd655;
	localparam logic [15:0]        GAIN_RST   = 16'd2163;

	// Configuration register indexes.
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_GAIN   = 1'b1;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_PROD    = 10'b00_0000_0010,
		S_NORM    = 10'b00_0000_0100,
		S_SQ      = 10'b00_0000_1000,
		S_ROOT_GO = 10'b00_0001_0000,
		S_ROOT    = 10'b00_0010_0000,
		S_DIV_GO  = 10'b00_0100_0000,
		S_DIV     = 10'b00_1000_0000,
		S_UPD     = 10'b01_0000_0000,
		S_FIN     = 10'b10_0000_0000
	} state_t;

	typedef enum logic [3:0] {
		A_QW, A_QX, A_QY, A_QZ, A_AX, A_AY, A_AZ, A_K14, A_K16,
		A_UNIT, A_DT, A_HI, A_LO
	} a_sel_t;

	typedef enum logic [3:0] {
		B_GX, B_GY, B_GZ, B_Q2W, B_Q2X, B_Q2Y, B_Q2Z, B_K14,
		B_F1D, B_F2D, B_F3Q, B_MAG, B_RATE, B_BETA, B_D
	} b_sel_t;

	typedef enum logic [1:0] {D_NONE, D_RATE, D_F, D_GRAD} dst_t;

	typedef struct packed {
		a_sel_t     a;
		b_sel_t     b;
		logic       neg;
		logic       clr;
		dst_t       dst;
		logic [1:0] idx;
	} prod_op_t;

	typedef struct packed {
		logic neg;
		logic clr;
		logic shl;
	} mac_ctl_t;

	typedef struct packed {
		logic start;
		logic div;
	} rd_ctl_t;

	// Product pass programme: rate terms, gravity objective, then gradient.
	function automatic prod_op_t prod_op(input logic [4:0] step);
		prod_op_t op;
		op = '{A_K16, B_RATE, 1'b0, 1'b1, D_NONE, 2'd0};
		case (step)
			5'd0:  op = '{A_QX, B_GX, 1'b1, 1'b1, D_NONE, 2'd0};
			5'd1:  op = '{A_QY, B_GY, 1'b1, 1'b0, D_NONE, 2'd0};
			5'd2:  op = '{A_QZ, B_GZ, 1'b1, 1'b0, D_RATE, 2'd0};
			5'd3:  op = '{A_QW, B_GX, 1'b0, 1'b1, D_NONE, 2'd1};
			5'd4:  op = '{A_QY, B_GZ, 1'b0, 1'b0, D_NONE, 2'd1};
			5'd5:  op = '{A_QZ, B_GY, 1'b1, 1'b0, D_RATE, 2'd1};
			5'd6:  op = '{A_QW, B_GY, 1'b0, 1'b1, D_NONE, 2'd2};
			5'd7:  op = '{A_QX, B_GZ, 1'b1, 1'b0, D_NONE, 2'd2};
			5'd8:  op = '{A_QZ, B_GX, 1'b0, 1'b0, D_RATE, 2'd2};
			5'd9:  op = '{A_QW, B_GZ, 1'b0, 1'b1, D_NONE, 2'd3};
			5'd10: op = '{A_QX, B_GY, 1'b0, 1'b0, D_NONE, 2'd3};
			5'd11: op = '{A_QY, B_GX, 1'b1, 1'b0, D_RATE, 2'd3};
			5'd12: op = '{A_QX, B_Q2Z, 1'b0, 1'b1, D_NONE, 2'd0};
			5'd13: op = '{A_QW, B_Q2Y, 1'b1, 1'b0, D_NONE, 2'd0};
			5'd14: op = '{A_AX, B_K14, 1'b1, 1'b0, D_F, 2'd0};
			5'd15: op = '{A_QW, B_Q2X, 1'b0, 1'b1, D_NONE, 2'd1};
			5'd16: op = '{A_QY, B_Q2Z, 1'b0, 1'b0, D_NONE, 2'd1};
			5'd17: op = '{A_AY, B_K14, 1'b1, 1'b0, D_F, 2'd1};
			5'd18: op = '{A_K14, B_K14, 1'b0, 1'b1, D_NONE, 2'd2};
			5'd19: op = '{A_QX, B_Q2X, 1'b1, 1'b0, D_NONE, 2'd2};
			5'd20: op = '{A_QY, B_Q2Y, 1'b1, 1'b0, D_NONE, 2'd2};
			5'd21: op = '{A_AZ, B_K14, 1'b1, 1'b0, D_F, 2'd2};
			5'd22: op = '{A_QY, B_F1D, 1'b1, 1'b1, D_NONE, 2'd0};
			5'd23: op = '{A_QX, B_F2D, 1'b0, 1'b0, D_GRAD, 2'd0};
			5'd24: op = '{A_QZ, B_F1D, 1'b0, 1'b1, D_NONE, 2'd1};
			5'd25: op = '{A_QW, B_F2D, 1'b0, 1'b0, D_NONE, 2'd1};
			5'd26: op = '{A_QX, B_F3Q, 1'b1, 1'b0, D_GRAD, 2'd1};
			5'd27: op = '{A_QW, B_F1D, 1'b1, 1'b1, D_NONE, 2'd2};
			5'd28: op = '{A_QZ, B_F2D, 1'b0, 1'b0, D_NONE, 2'd2};
			5'd29: op = '{A_QY, B_F3Q, 1'b1, 1'b0, D_GRAD, 2'd2};
			5'd30: op = '{A_QX, B_F1D, 1'b0, 1'b1, D_NONE, 2'd3};
			5'd31: op = '{A_QY, B_F2D, 1'b0, 1'b0, D_GRAD, 2'd3};
			default: op = '{A_K16, B_RATE, 1'b0, 1'b1, D_NONE, 2'd0};
		endcase
		return op;
	endfunction

endpackage

// ----- src/igau_mac.sv -----
`timescale 1ns / 1ps
module igau_mac (
	input  logic                                clk,
	input  igau_pkg::mac_ctl_t                  ctl,
	input  logic signed [igau_pkg::A_W-1:0]     a,
	input  logic signed [igau_pkg::B_W-1:0]     b,
	output logic signed [igau_pkg::ACC_W-1:0]   acc,
	output logic signed [igau_pkg::ACC_W-1:0]   acc_nx
);
	import igau_pkg::*;

	logic signed [P_W-1:0]   prod;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] acc_q;

	// Shared signed multiplier with optional scaling and negation of the product.
	assign prod = a * b;

	always_comb begin
		term = ACC_W'(prod);
		if (ctl.shl) begin
			term = term <<< SQ_SH;
		end
		if (ctl.neg) begin
			term = -term;
		end
	end

	// Accumulator, cleared by the first term of each sum.
	assign acc_nx = (ctl.clr ? '0 : acc_q) + term;

	always_ff @(posedge clk) begin
		acc_q <= acc_nx;
	end

	assign acc = acc_q;

endmodule

// ----- src/igau_rootdiv.sv -----
`timescale 1ns / 1ps
module igau_rootdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  igau_pkg::rd_ctl_t                 ctl,
	input  logic [igau_pkg::ACC_W-1:0]        rad,
	input  logic [igau_pkg::NRM_W-1:0]        num,
	input  logic [igau_pkg::NORM_W-1:0]       den,
	output logic                              done,
	output logic [igau_pkg::NORM_W-1:0]       root,
	output logic [igau_pkg::QU_W-1:0]         quot
);
	import igau_pkg::*;

	logic             busy_q;
	logic             div_q;
	logic             done_q;
	logic [4:0]       cnt_q;
	logic [ACC_W-1:0] x_q;
	logic [ACC_W-1:0] res_q;
	logic [ACC_W-1:0] bit_q;
	logic             nb_q;

	logic [ACC_W-1:0] xr;
	logic [ACC_W-1:0] y;
	logic [ACC_W:0]   diff;
	logic             ge;

	// One shared subtract and compare serves both the root and the divide step.
	assign xr   = div_q ? {x_q[ACC_W-2:0], nb_q} : x_q;
	assign y    = div_q ? ACC_W'(den) : (res_q | bit_q);
	assign diff = {1'b0, xr} - {1'b0, y};
	assign ge   = !diff[ACC_W];

	// Iteration counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (ctl.start) begin
				busy_q <= 1'b1;
				div_q  <= ctl.div;
				cnt_q  <= ctl.div ? 5'(DIV_ITER - 1) : 5'(ROOT_ITER - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Restoring root two bits a step, restoring divide one quotient bit a step.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			res_q <= '0;
			bit_q <= ACC_W'(1) << ROOT_TOP;
			if (ctl.div) begin
				x_q  <= ACC_W'(num >> 1);
				nb_q <= num[0];
			end else begin
				x_q  <= rad;
				nb_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (div_q) begin
				x_q   <= ge ? diff[ACC_W-1:0] : xr;
				res_q <= {res_q[ACC_W-2:0], ge};
				nb_q  <= 1'b0;
			end else begin
				if (ge) begin
					x_q   <= diff[ACC_W-1:0];
					res_q <= (res_q >> 1) | bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[NORM_W-1:0];
	assign quot = res_q[QU_W-1:0];

endmodule

// ----- src/imu_gradient_attitude_update.sv -----
// Channel  Handshake            Payload
// cfg      cfg_en               cfg_index, cfg_data (period, gain)
// in       in_valid / in_stall  gyro_x..z, accel_x..z
// out      out_valid / out_stall quat_w, quat_x, quat_y, quat_z
// One beat is processed at a time; the next input beat is taken once the result is registered.
// An update runs the shared multiply-accumulate passes,
// the 32-step square root and four 15-step divides; a zero gradient skips the divides.
// Reset restores the identity attitude and the register defaults, and leaves the block idle.
// A stalled result holds in the output register; the block waits before overwriting it.
`timescale 1ns / 1ps
module imu_gradient_attitude_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_en,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z
);
	import igau_pkg::*;

`include "imu_gradient_attitude_update_defines.svh"

	state_t                  state_q;
	logic [4:0]              step_q;
	logic [1:0]              comp_q;
	logic [1:0]              sub_q;
	logic [15:0]             dt_q;
	logic [15:0]             beta_q;
	logic signed [15:0]      att_q [4];
	logic                    out_valid_q;
	logic signed [15:0]      ow_q, ox_q, oy_q, oz_q;

	logic signed [15:0]      gx_q, gy_q, gz_q, ax_q, ay_q, az_q;
	logic signed [R_W-1:0]   rate_q [4];
	logic signed [F_W-1:0]   f_q [3];
	logic [MAG_W-1:0]        mag_q [4];
	logic [3:0]              gneg_q;
	logic [NORM_W-1:0]       norm_q;
	logic signed [15:0]      unit_q [4];
	logic signed [D_W-1:0]   d_q;

	prod_op_t                pop;
	logic [1:0]              sel;
	a_sel_t                  a_sel;
	b_sel_t                  b_sel;
	mac_ctl_t                mctl;
	logic signed [A_W-1:0]   a_val;
	logic signed [B_W-1:0]   b_val;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_nx;
	logic [ACC_W-1:0]        acc_abs;
	logic [MAG_W-1:0]        mag_or;
	logic                    mag_big;
	logic signed [ACC_W-1:0] v_rnd;
	logic signed [33:0]      inc;
	logic signed [33:0]      att_sum;
	logic signed [15:0]      att_new;
	rd_ctl_t                 rctl;
	logic                    rd_done;
	logic [NORM_W-1:0]       rd_root;
	logic [QU_W-1:0]         rd_quot;

	assign pop = prod_op(step_q);
	assign sel = (state_q == S_SQ) ? step_q[2:1] : comp_q;

	// Operand and accumulator control for the current step.
	always_comb begin
		a_sel = A_K16;
		b_sel = B_RATE;
		mctl  = '{neg: 1'b0, clr: 1'b1, shl: 1'b0};
		case (state_q)
			S_PROD: begin
				a_sel    = pop.a;
				b_sel    = pop.b;
				mctl.neg = pop.neg;
				mctl.clr = pop.clr;
			end
			S_SQ: begin
				a_sel    = step_q[0] ? A_LO : A_HI;
				b_sel    = B_MAG;
				mctl.clr = (step_q[2:0] == 3'd0);
				mctl.shl = !step_q[0];
			end
			S_UPD: begin
				case (sub_q)
					2'd0: begin
						a_sel = A_K16;
						b_sel = B_RATE;
					end
					2'd1: begin
						a_sel    = A_UNIT;
						b_sel    = B_BETA;
						mctl.neg = 1'b1;
						mctl.clr = 1'b0;
					end
					default: begin
						a_sel = A_DT;
						b_sel = B_D;
					end
				endcase
			end
			default: ;
		endcase
	end

	// Multiplier operand A.
	always_comb begin
		case (a_sel)
			A_QW:    a_val = A_W'(att_q[0]);
			A_QX:    a_val = A_W'(att_q[1]);
			A_QY:    a_val = A_W'(att_q[2]);
			A_QZ:    a_val = A_W'(att_q[3]);
			A_AX:    a_val = A_W'(ax_q);
			A_AY:    a_val = A_W'(ay_q);
			A_AZ:    a_val = A_W'(az_q);
			A_K14:   a_val = A_W'(Q_ONE);
			A_UNIT:  a_val = A_W'(unit_q[sel]);
			A_DT:    a_val = A_W'(dt_q);
			A_HI:    a_val = A_W'(mag_q[sel][NRM_W-1:SQ_SH]);
			A_LO:    a_val = A_W'(mag_q[sel][SQ_SH-1:0]);
			default: a_val = A_W'(16);
		endcase
	end

	// Multiplier operand B.
	always_comb begin
		case (b_sel)
			B_GX:    b_val = B_W'(gx_q);
			B_GY:    b_val = B_W'(gy_q);
			B_GZ:    b_val = B_W'(gz_q);
			B_Q2W:   b_val = B_W'(att_q[0]) <<< 1;
			B_Q2X:   b_val = B_W'(att_q[1]) <<< 1;
			B_Q2Y:   b_val = B_W'(att_q[2]) <<< 1;
			B_Q2Z:   b_val = B_W'(att_q[3]) <<< 1;
			B_K14:   b_val = B_W'(Q_ONE);
			B_F1D:   b_val = B_W'(f_q[0]) <<< 1;
			B_F2D:   b_val = B_W'(f_q[1]) <<< 1;
			B_F3Q:   b_val = B_W'(f_q[2]) <<< 2;
			B_MAG:   b_val = B_W'(mag_q[sel][NRM_W-1:0]);
			B_BETA:  b_val = B_W'(beta_q);
			B_D:     b_val = B_W'(d_q);
			default: b_val = B_W'(rate_q[sel]);
		endcase
	end

	igau_mac u_mac (
		.clk    (clk),
		.ctl    (mctl),
		.a      (a_val),
		.b      (b_val),
		.acc    (acc_q),
		.acc_nx (acc_nx)
	);

	assign rctl.start = (state_q == S_ROOT_GO) || (state_q == S_DIV_GO);
	assign rctl.div   = (state_q == S_DIV_GO);

	igau_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.rad    (acc_q),
		.num    (mag_q[sel][NRM_W-1:0]),
		.den    (norm_q),
		.done   (rd_done),
		.root   (rd_root),
		.quot   (rd_quot)
	);

	// Gradient magnitude and the normalising shift test.
	assign acc_abs = acc_nx[ACC_W-1] ? -acc_nx : acc_nx;
	assign mag_or  = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];
	assign mag_big = |mag_or[MAG_W-1:NRM_W];

	// Increment rounded half up to Q14, then the saturating attitude sum.
	always_comb begin
		v_rnd   = acc_nx + (ACC_W'(1) <<< 31);
		inc     = 34'(v_rnd >>> 32);
		att_sum = 34'(att_q[comp_q]) + inc;
		if (att_sum > 34'sd32767) begin
			att_new = 16'sh7FFF;
		end else if (att_sum < -34'sd32768) begin
			att_new = 16'sh8000;
		end else begin
			att_new = att_sum[15:0];
		end
	end

	// Sequencer, configuration, attitude and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			comp_q      <= '0;
			sub_q       <= '0;
			dt_q        <= PERIOD_RST;
			beta_q      <= GAIN_RST;
			att_q[0]    <= Q_ONE;
			att_q[1]    <= '0;
			att_q[2]    <= '0;
			att_q[3]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_en) begin
				case (cfg_index)
					REG_PERIOD: dt_q   <= cfg_data;
					REG_GAIN:   beta_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q  <= '0;
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (!mag_big) begin
						step_q  <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd7) begin
						state_q <= S_ROOT_GO;
					end
				end
				S_ROOT_GO: state_q <= S_ROOT;
				S_ROOT: begin
					if (rd_done) begin
						comp_q  <= '0;
						sub_q   <= '0;
						state_q <= (rd_root == '0) ? S_UPD : S_DIV_GO;
					end
				end
				S_DIV_GO: state_q <= S_DIV;
				S_DIV: begin
					if (rd_done) begin
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd3) begin
							sub_q   <= '0;
							state_q <= S_UPD;
						end else begin
							state_q <= S_DIV_GO;
						end
					end
				end
				S_UPD: begin
					case (sub_q)
						2'd0: sub_q <= 2'd1;
						2'd1: sub_q <= 2'd2;
						default: begin
							att_q[comp_q] <= att_new;
							sub_q         <= 2'd0;
							comp_q        <= comp_q + 2'd1;
							if (comp_q == 2'd3) begin
								state_q <= S_FIN;
							end
						end
					endcase
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working values of the update in progress.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					gx_q <= gyro_x;
					gy_q <= gyro_y;
					gz_q <= gyro_z;
					ax_q <= accel_x;
					ay_q <= accel_y;
					az_q <= accel_z;
				end
			end
			S_PROD: begin
				case (pop.dst)
					D_RATE: rate_q[pop.idx] <= acc_nx[R_W-1:0];
					D_F:    f_q[pop.idx] <= acc_nx[F_W-1:0];
					D_GRAD: begin
						gneg_q[pop.idx] <= acc_nx[ACC_W-1];
						mag_q[pop.idx]  <= acc_abs[MAG_W-1:0];
					end
					default: ;
				endcase
			end
			S_NORM: begin
				if (mag_big) begin
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
					mag_q[3] <= mag_q[3] >> 1;
				end
			end
			S_ROOT: begin
				if (rd_done) begin
					norm_q    <= rd_root;
					unit_q[0] <= '0;
					unit_q[1] <= '0;
					unit_q[2] <= '0;
					unit_q[3] <= '0;
				end
			end
			S_DIV: begin
				if (rd_done) begin
					unit_q[comp_q] <= gneg_q[comp_q] ? -16'(rd_quot) : 16'(rd_quot);
				end
			end
			S_UPD: begin
				if (sub_q == 2'd1) begin
					d_q <= acc_nx[D_W-1:0];
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					ow_q <= att_q[0];
					ox_q <= att_q[1];
					oy_q <= att_q[2];
					oz_q <= att_q[3];
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign quat_w    = ow_q;
	assign quat_x    = ox_q;
	assign quat_y    = oy_q;
	assign quat_z    = oz_q;

	`IGAU_AST_NXT(a_beat_starts, in_valid && !in_stall, state_q == S_PROD, "accepted beat did not start the product pass")
	`IGAU_AST_IMP(a_done_phase, rd_done, state_q == S_ROOT || state_q == S_DIV, "root or divide finished outside its phase")
	`IGAU_AST_IMP(a_out_from_fin, $rose(out_valid), $past(state_q == S_FIN), "result raised without a finished update")
	`IGAU_AST_IMP(a_sq_normalised, state_q == S_SQ, mag_or[MAG_W-1:NRM_W] == '0, "squares taken before the gradient was normalised")
	`IGAU_AST_IMP(a_sq_steps, state_q == S_SQ, step_q[4:3] == 2'd0, "square pass ran beyond its eight steps")

endmodule
